// ===== rtl/spd_pkg.sv =====
// shared types, constants and the table function for the scope peak decimator
`default_nettype none

package spd_pkg;

   localparam int SAMPLES_PER_BUFFER = 128;
   localparam int BAR_SLOTS          = 128;
   localparam int POINT_COLUMNS      = 128;
   localparam int QUEUE_DEPTH        = 4;

   localparam int POS_W   = $clog2(SAMPLES_PER_BUFFER);
   localparam int HEAD_W  = $clog2(BAR_SLOTS);
   localparam int PCOL_W  = $clog2(POINT_COLUMNS);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int SLOT_W  = 7;
   localparam int ROW_W   = 6;
   localparam int SMP_W   = 16;
   localparam int CSR_W   = 7;
   localparam int CIDX_W  = 3;
   localparam int CNT_W   = 9;

   typedef enum logic [CIDX_W-1:0] {
      CSR_SCOPE_ENABLE = 3'd0,
      CSR_BAR_MODE     = 3'd1,
      CSR_ZOOM_LEVEL   = 3'd2,
      CSR_STRIDE_LEVEL = 3'd3,
      CSR_SKIP_INDEX   = 3'd4
   } csr_index_type;

   // one queued result, rows still as raw samples
   typedef struct packed {
      logic                    is_bar;
      logic                    stored;
      logic [SLOT_W-1:0]       slot;
      logic                    redraw;
      logic signed [SMP_W-1:0] hi;
      logic signed [SMP_W-1:0] lo;
   } entry_type;

   // power-of-two table {0,1,2,4,...,256}, index saturated at 9
   function automatic logic [CNT_W-1:0] pow_table(input logic [3:0] idx);
      logic [3:0] i;
      i = (idx > 4'd9) ? 4'd9 : idx;
      if (i == 4'd0) begin
         pow_table = '0;
      end else begin
         pow_table = CNT_W'(1) << (i - 4'd1);
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spd_front.sv =====
// front end: configuration, buffer tracking, stride and frame decisions
`default_nettype none

module spd_front
   import spd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [CIDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]        csr_data,
   input  wire logic                    accept,
   input  wire logic signed [SMP_W-1:0] sample,
   output      logic                    push,
   output      entry_type               push_entry,
   output      logic [2:0]              zoom_step
);

   logic                    scope_enable_ff;
   logic                    bar_mode_ff;
   logic [6:0]              zoom_level_ff;
   logic [6:0]              stride_level_ff;
   logic [3:0]              skip_index_ff;

   logic [POS_W-1:0]        position_ff, position_in;
   logic signed [SMP_W-1:0] run_min_ff, run_min_in;
   logic signed [SMP_W-1:0] run_max_ff, run_max_in;
   logic [CNT_W-1:0]        buffer_count_ff, buffer_count_in;
   logic [HEAD_W-1:0]       bar_head_ff, bar_head_in;
   logic [CNT_W-1:0]        frame_count_ff, frame_count_in;
   logic [PCOL_W-1:0]       point_count_ff, point_count_in;

   logic [10:0]             zoom_prod;
   logic [10:0]             stride_prod;
   logic [CNT_W-1:0]        stride_val;
   logic [CNT_W-1:0]        bc_inc;
   logic                    last;
   logic                    aligned;
   logic                    bar_store;
   logic                    point_last;
   logic                    frame_req;
   logic                    frame_due;
   logic                    active;

   assign zoom_prod   = {4'd0, zoom_level_ff} * 11'd6;
   assign zoom_step   = zoom_prod[9:7];
   assign stride_prod = {4'd0, stride_level_ff} * 11'd10;

   always_comb begin
      stride_val = pow_table(stride_prod[10:7]);
      if (stride_val == '0) begin
         stride_val = CNT_W'(1);
      end
   end

   assign active     = accept && scope_enable_ff;
   assign last       = (position_ff == POS_W'(SAMPLES_PER_BUFFER - 1));
   assign aligned    = ((position_ff & POS_W'(stride_val - CNT_W'(1))) == '0);
   assign bc_inc     = buffer_count_ff + CNT_W'(1);
   assign bar_store  = (bc_inc >= stride_val);
   assign point_last = (point_count_ff == PCOL_W'(POINT_COLUMNS - 1));
   assign frame_req  = bar_mode_ff ? (last && bar_store) : (aligned && point_last);
   assign frame_due  = (frame_count_ff >= pow_table(skip_index_ff));

   always_comb begin
      position_in     = last ? '0 : position_ff + POS_W'(1);
      buffer_count_in = buffer_count_ff;
      bar_head_in     = bar_head_ff;
      point_count_in  = point_count_ff;
      frame_count_in  = frame_count_ff;

      if (position_ff == '0) begin
         run_min_in = sample;
         run_max_in = sample;
      end else begin
         run_min_in = (sample < run_min_ff) ? sample : run_min_ff;
         run_max_in = (sample > run_max_ff) ? sample : run_max_ff;
      end

      if (bar_mode_ff) begin
         if (last) begin
            buffer_count_in = bar_store ? '0 : bc_inc;
            if (bar_store) begin
               bar_head_in = (bar_head_ff == HEAD_W'(BAR_SLOTS - 1)) ?
                             '0 : bar_head_ff + HEAD_W'(1);
            end
         end
      end else if (aligned) begin
         point_count_in = point_last ? '0 : point_count_ff + PCOL_W'(1);
      end

      if (frame_req) begin
         frame_count_in = frame_due ? '0 : frame_count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      push                = active && (bar_mode_ff ? last : aligned);
      push_entry.is_bar   = bar_mode_ff;
      push_entry.stored   = bar_mode_ff ? bar_store : 1'b1;
      push_entry.redraw   = frame_req && frame_due;
      push_entry.hi       = bar_mode_ff ? run_max_in : sample;
      push_entry.lo       = bar_mode_ff ? run_min_in : sample;
      if (bar_mode_ff) begin
         push_entry.slot = bar_store ? SLOT_W'(bar_head_ff) : '0;
      end else begin
         push_entry.slot = SLOT_W'(point_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scope_enable_ff <= 1'b0;
         bar_mode_ff     <= 1'b0;
         zoom_level_ff   <= '0;
         stride_level_ff <= '0;
         skip_index_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCOPE_ENABLE: scope_enable_ff <= csr_data[0];
            CSR_BAR_MODE:     bar_mode_ff     <= csr_data[0];
            CSR_ZOOM_LEVEL:   zoom_level_ff   <= csr_data;
            CSR_STRIDE_LEVEL: stride_level_ff <= csr_data;
            CSR_SKIP_INDEX:   skip_index_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         run_min_ff      <= '0;
         run_max_ff      <= '0;
         buffer_count_ff <= '0;
         bar_head_ff     <= '0;
         frame_count_ff  <= '0;
         point_count_ff  <= '0;
      end else if (active) begin
         position_ff     <= position_in;
         run_min_ff      <= run_min_in;
         run_max_ff      <= run_max_in;
         buffer_count_ff <= buffer_count_in;
         bar_head_ff     <= bar_head_in;
         frame_count_ff  <= frame_count_in;
         point_count_ff  <= point_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spd_queue.sv =====
// short result queue between front and back
`default_nettype none

module spd_queue
   import spd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output      logic       not_empty,
   output      logic       full,
   output      entry_type  head
);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push;
   logic              do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (QPTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (QPTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spd_back.sv =====
// back end: sample to pixel row scaling and the output register
`default_nettype none

module spd_back
   import spd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        zoom_step,
   input  wire logic              q_not_empty,
   input  wire entry_type         q_head,
   output      logic              q_pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_is_bar,
   output      logic              rsp_stored,
   output      logic [SLOT_W-1:0] rsp_slot,
   output      logic [ROW_W-1:0]  rsp_row_upper,
   output      logic [ROW_W-1:0]  rsp_row_lower,
   output      logic              rsp_redraw
);

   logic                 a_valid_ff;
   logic                 a_is_bar_ff;
   logic                 a_stored_ff;
   logic [SLOT_W-1:0]    a_slot_ff;
   logic                 a_redraw_ff;
   logic signed [20:0]   a_prod_hi_ff;
   logic signed [20:0]   a_prod_lo_ff;
   logic                 out_valid_ff;
   logic                 out_is_bar_ff;
   logic                 out_stored_ff;
   logic [SLOT_W-1:0]    out_slot_ff;
   logic [ROW_W-1:0]     out_upper_ff;
   logic [ROW_W-1:0]     out_lower_ff;
   logic                 out_redraw_ff;
   logic                 out_ready;
   logic                 a_ready;

   // 39 - trunc(prod / 2^(15-zoom)), clamped to 16..63
   function automatic logic [ROW_W-1:0] to_row(input logic signed [20:0] prod,
                                                input logic [2:0] zoom);
      logic [3:0]         k;
      logic signed [20:0] bias;
      logic signed [20:0] q;
      logic signed [21:0] y;
      k    = 4'd15 - {1'b0, zoom};
      bias = (prod < 0) ? $signed((21'd1 << k) - 21'd1) : 21'sd0;
      q    = (prod + bias) >>> k;
      y    = 22'sd39 - {q[20], q};
      if (y < 22'sd16) begin
         to_row = ROW_W'(16);
      end else if (y > 22'sd63) begin
         to_row = ROW_W'(63);
      end else begin
         to_row = y[ROW_W-1:0];
      end
   endfunction

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign a_ready   = !a_valid_ff || out_ready;
   assign q_pop     = q_not_empty && a_ready;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_is_bar_ff  <= q_head.is_bar;
         a_stored_ff  <= q_head.stored;
         a_slot_ff    <= q_head.slot;
         a_redraw_ff  <= q_head.redraw;
         a_prod_hi_ff <= 21'(q_head.hi) * 21'sd23;
         a_prod_lo_ff <= 21'(q_head.lo) * 21'sd23;
      end
      if (a_valid_ff && out_ready) begin
         out_is_bar_ff <= a_is_bar_ff;
         out_stored_ff <= a_stored_ff;
         out_slot_ff   <= a_slot_ff;
         out_redraw_ff <= a_redraw_ff;
         out_upper_ff  <= a_stored_ff ? to_row(a_prod_hi_ff, zoom_step) : '0;
         out_lower_ff  <= a_stored_ff ? to_row(a_prod_lo_ff, zoom_step) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= q_pop;
         end
         if (out_ready) begin
            out_valid_ff <= a_valid_ff;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_is_bar    = out_is_bar_ff;
   assign rsp_stored    = out_stored_ff;
   assign rsp_slot      = out_slot_ff;
   assign rsp_row_upper = out_upper_ff;
   assign rsp_row_lower = out_lower_ff;
   assign rsp_redraw    = out_redraw_ff;

endmodule

`default_nettype wire

// ===== rtl/scope_peak_decimator.sv =====
// top level of the scope peak decimator
//
// Samples enter on the req_ channel (req_valid, req_stall, req_sample) and are
// taken at an edge with req_valid high and req_stall low. While the scope is
// enabled, each sample updates the buffer position, the running min/max and the
// bar/point counters in the front end; a sample that ends a buffer in bar mode,
// or lands on a stride position in point mode, produces one result. Results
// leave on the rsp_ channel: is_bar, stored, slot, row_upper, row_lower and
// redraw. The user writes registers through csr_write/csr_index/csr_data only
// while idle; the block does not enforce this. Throughput is one sample per
// cycle while req_stall is low. A result goes from its sample transfer through
// the queue (written at the transfer edge), the row multiplier stage and the
// output register to rsp_valid. When the receiver holds rsp_stall, the output
// register and multiplier stage hold, the four-entry queue fills, and req_stall
// rises once the queue is full. Synchronous reset clears the configuration, the
// counters, the queue and the pipeline valid flags; the block is ready for a
// transfer in the first cycle after reset.
`default_nettype none

module scope_peak_decimator
   import spd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [CIDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]        csr_data,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic signed [SMP_W-1:0] req_sample,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic                    rsp_is_bar,
   output      logic                    rsp_stored,
   output      logic [SLOT_W-1:0]       rsp_slot,
   output      logic [ROW_W-1:0]        rsp_row_upper,
   output      logic [ROW_W-1:0]        rsp_row_lower,
   output      logic                    rsp_redraw
);

   logic       accept;
   logic       push;
   entry_type  push_entry;
   logic [2:0] zoom_step;
   logic       q_not_empty;
   logic       q_full;
   logic       q_pop;
   entry_type  q_head;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   spd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .sample     (req_sample),
      .push       (push),
      .push_entry (push_entry),
      .zoom_step  (zoom_step)
   );

   spd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .full       (q_full),
      .head       (q_head)
   );

   spd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .zoom_step     (zoom_step),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_bar    (rsp_is_bar),
      .rsp_stored    (rsp_stored),
      .rsp_slot      (rsp_slot),
      .rsp_row_upper (rsp_row_upper),
      .rsp_row_lower (rsp_row_lower),
      .rsp_redraw    (rsp_redraw)
   );

endmodule

`default_nettype wire
